// ----- hw/rtl/natrw_pkg.sv -----
// types, constants and checksum helpers shared by the nat header rewrite block
`timescale 1ns / 1ps

package natrw_pkg;

   localparam logic [7:0]  PROTO_TCP     = 8'd6;
   localparam logic [7:0]  PROTO_UDP     = 8'd17;
   localparam logic [15:0] CSUM_ZERO_SUB = 16'hFFFF;
   localparam logic [16:0] TTL_CSUM_ADJ  = 17'h00100;
   localparam logic [16:0] CSUM_WRAP     = 17'h0FFFF;

   typedef enum logic [1:0] {
      STEP_SNAT_PORT,
      STEP_SNAT_ADDR,
      STEP_DNAT_PORT,
      STEP_DNAT_ADDR
   } step_type;

   typedef struct packed {
      logic [31:0] src_addr;
      logic [31:0] dest_addr;
      logic [15:0] source_port;
      logic [15:0] dest_port;
      logic [7:0]  hop_ttl;
      logic [7:0]  protocol;
      logic [15:0] ip_checksum;
      logic [15:0] l4_checksum;
      logic [1:0]  nat_mode;
      logic        direction;
      logic [63:0] nat_addresses;
      logic [31:0] nat_ports;
   } req_type;

   typedef struct packed {
      logic [31:0] new_src_addr;
      logic [31:0] new_dst_addr;
      logic [15:0] new_src_port;
      logic [15:0] new_dst_port;
      logic [7:0]  new_ttl;
      logic [15:0] new_ip_checksum;
      logic [15:0] new_l4_checksum;
   } rsp_type;

   // 32-bit add with end-around carry
   function automatic logic [31:0] ones_add32(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] r;
      r = {1'b0, a} + {1'b0, b};
      return r[31:0] + {31'd0, r[32]};
   endfunction

   function automatic logic [15:0] fold_not16(input logic [31:0] c);
      logic [16:0] c1;
      logic [16:0] c2;
      c1 = {1'b0, c[15:0]} + {1'b0, c[31:16]};
      c2 = {1'b0, c1[15:0]} + {16'd0, c1[16]};
      return ~c2[15:0];
   endfunction

   function automatic logic [15:0] replace_word(input logic [15:0] check,
                                                input logic [31:0] from,
                                                input logic [31:0] to);
      logic [31:0] t;
      t = ones_add32(~{16'd0, check}, ~from);
      return fold_not16(ones_add32(t, to));
   endfunction

   function automatic logic [15:0] l4_update(input logic [7:0]  proto,
                                             input logic [15:0] l4,
                                             input logic [31:0] from,
                                             input logic [31:0] to);
      logic [15:0] r;
      r = replace_word(l4, from, to);
      priority if (proto == PROTO_TCP) begin
         return r;
      end else if (proto == PROTO_UDP) begin
         // udp zero means no checksum
         if (l4 == 16'd0) begin
            return 16'd0;
         end
         return (r == 16'd0) ? CSUM_ZERO_SUB : r;
      end else begin
         return l4;
      end
   endfunction

endpackage

// ----- hw/rtl/natrw_step.sv -----
// one registered rewrite step: a port or address replacement with checksum update
`timescale 1ns / 1ps

module natrw_step
   import natrw_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  step_type step,
   input  logic     in_valid,
   input  req_type  in_item,
   output logic     out_valid,
   output req_type  out_item
);

   logic    valid_ff;
   req_type item_ff;
   req_type item_in;

   logic        is_snat;
   logic        is_addr;
   logic        enabled;
   logic        to_src;
   logic [31:0] old_val;
   logic [31:0] new_val;

   always_comb begin
      is_snat = 1'b0;
      is_addr = 1'b0;
      unique case (step)
         STEP_SNAT_PORT: begin is_snat = 1'b1; is_addr = 1'b0; end
         STEP_SNAT_ADDR: begin is_snat = 1'b1; is_addr = 1'b1; end
         STEP_DNAT_PORT: begin is_snat = 1'b0; is_addr = 1'b0; end
         STEP_DNAT_ADDR: begin is_snat = 1'b0; is_addr = 1'b1; end
         default:        begin is_snat = 1'b0; is_addr = 1'b0; end
      endcase
   end

   always_comb begin
      item_in = in_item;
      enabled = is_snat ? in_item.nat_mode[0] : in_item.nat_mode[1];
      to_src  = is_snat ^ in_item.direction;
      if (is_addr) begin
         old_val = to_src ? in_item.src_addr : in_item.dest_addr;
         new_val = is_snat ? in_item.nat_addresses[63:32] : in_item.nat_addresses[31:0];
      end else begin
         old_val = {16'd0, to_src ? in_item.source_port : in_item.dest_port};
         new_val = {16'd0, is_snat ? in_item.nat_ports[31:16] : in_item.nat_ports[15:0]};
      end
      if (enabled) begin
         item_in.l4_checksum = l4_update(in_item.protocol, in_item.l4_checksum,
                                         old_val, new_val);
         if (is_addr) begin
            item_in.ip_checksum = replace_word(in_item.ip_checksum, old_val, new_val);
            if (to_src) begin
               item_in.src_addr = new_val;
            end else begin
               item_in.dest_addr = new_val;
            end
         end else begin
            if (to_src) begin
               item_in.source_port = new_val[15:0];
            end else begin
               item_in.dest_port = new_val[15:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// ----- hw/rtl/ipv4_nat_header_rewrite_top.sv -----
// an accepted start passes the snat port, snat addr, dnat port and dnat addr registers, then the ttl output register
// throughput: one header per cycle; busy stays low, four rewrite stages and a ttl stage
// each rewrite stage holds one port or address replacement with its checksum updates, valid bits travel with the data
// reset (synchronous, active high) clears all valid bits; payload registers are not reset
// results are strobed for one cycle, the receiver cannot hold them off
`timescale 1ns / 1ps

module ipv4_nat_header_rewrite_top
   import natrw_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   localparam int NumSteps = 4;

   logic    stage_valid [NumSteps+1];
   req_type stage_item  [NumSteps+1];

   logic        rsp_valid_ff;
   rsp_type     rsp_item_ff;
   rsp_type     rsp_item_in;
   logic [16:0] ttl_sum;
   logic [16:0] ttl_fix;

   assign busy           = 1'b0;
   assign stage_valid[0] = start & ~busy;
   assign stage_item[0]  = req_item;

   natrw_step u_snat_port (
      .clock(clock), .reset(reset), .step(STEP_SNAT_PORT),
      .in_valid(stage_valid[0]), .in_item(stage_item[0]),
      .out_valid(stage_valid[1]), .out_item(stage_item[1])
   );

   natrw_step u_snat_addr (
      .clock(clock), .reset(reset), .step(STEP_SNAT_ADDR),
      .in_valid(stage_valid[1]), .in_item(stage_item[1]),
      .out_valid(stage_valid[2]), .out_item(stage_item[2])
   );

   natrw_step u_dnat_port (
      .clock(clock), .reset(reset), .step(STEP_DNAT_PORT),
      .in_valid(stage_valid[2]), .in_item(stage_item[2]),
      .out_valid(stage_valid[3]), .out_item(stage_item[3])
   );

   natrw_step u_dnat_addr (
      .clock(clock), .reset(reset), .step(STEP_DNAT_ADDR),
      .in_valid(stage_valid[3]), .in_item(stage_item[3]),
      .out_valid(stage_valid[4]), .out_item(stage_item[4])
   );

   // ttl decrement with checksum adjust
   always_comb begin
      ttl_sum = {1'b0, stage_item[NumSteps].ip_checksum} + TTL_CSUM_ADJ;
      ttl_fix = ttl_sum + {16'd0, (ttl_sum >= CSUM_WRAP)};
      rsp_item_in.new_src_addr    = stage_item[NumSteps].src_addr;
      rsp_item_in.new_dst_addr    = stage_item[NumSteps].dest_addr;
      rsp_item_in.new_src_port    = stage_item[NumSteps].source_port;
      rsp_item_in.new_dst_port    = stage_item[NumSteps].dest_port;
      rsp_item_in.new_ttl         = stage_item[NumSteps].hop_ttl - 8'd1;
      rsp_item_in.new_ip_checksum = ttl_fix[15:0];
      rsp_item_in.new_l4_checksum = stage_item[NumSteps].l4_checksum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= stage_valid[NumSteps];
      end
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule
